### rtl/vfts_pkg.sv
package vfts_pkg;

  localparam int unsigned FracBits  = 8;
  localparam int unsigned CoordBits = 5;
  localparam int unsigned PosBits   = CoordBits + FracBits;
  localparam int unsigned CompBits  = 16;
  localparam int unsigned DimBits   = 6;
  localparam int unsigned MaxDim    = 32;
  localparam int unsigned NumBanks  = 8;
  localparam int unsigned BankAw    = 3 * (CoordBits - 1);
  localparam int unsigned BankDepth = 1 << BankAw;
  localparam int unsigned QDepth    = 4;

  typedef enum logic [1:0] {
    REG_DIM_X = 2'd0,
    REG_DIM_Y = 2'd1,
    REG_DIM_Z = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef struct packed {
    logic                       func;
    logic [14:0]                voxel_index;
    logic signed [CompBits-1:0] write_x;
    logic signed [CompBits-1:0] write_y;
    logic signed [CompBits-1:0] write_z;
    logic [PosBits-1:0]         pos_x;
    logic [PosBits-1:0]         pos_y;
    logic [PosBits-1:0]         pos_z;
  } in_item_t;

  typedef struct packed {
    logic                       valid_res;
    logic signed [CompBits-1:0] out_x;
    logic signed [CompBits-1:0] out_y;
    logic signed [CompBits-1:0] out_z;
  } out_item_t;

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic [3*CompBits-1:0]      voxel_t;
  typedef logic [BankAw-1:0]          baddr_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                         is_wr;
    logic                         in_vol;
    logic [2:0]                   wbank;
    baddr_t                       waddr;
    voxel_t                       wdata;
    logic [NumBanks*BankAw-1:0]   raddr;
    logic [2:0]                   par0;   // parity of lower corner {s,r,c}
    logic [2:0]                   par1;   // parity of upper corner {s,r,c}
    logic [FracBits-1:0]          tx;
    logic [FracBits-1:0]          ty;
    logic [FracBits-1:0]          tz;
  } cmd_t;

  // a + floor(t*(b-a) / 2^FracBits)
  function automatic comp_t lerp(comp_t a, comp_t b, logic [FracBits-1:0] t);
    logic signed [CompBits:0]            diff;
    logic signed [CompBits+FracBits+1:0] prod;
    logic signed [CompBits+1:0]          sum;
    diff = {b[CompBits-1], b} - {a[CompBits-1], a};
    prod = diff * $signed({1'b0, t});
    sum  = {{2{a[CompBits-1]}}, a} + prod[CompBits+FracBits+1:FracBits];
    return sum[CompBits-1:0];
  endfunction

endpackage

### rtl/vfts_front.sv
module vfts_front import vfts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [DimBits-1:0] cfg_wdata_i,
  input  in_item_t           item_i,
  output cmd_t               cmd_o
);

  logic [DimBits-1:0] dim_q [3];
  logic [CoordBits-1:0] dm1 [3];
  logic [CoordBits-1:0] crd [3];
  logic [CoordBits-1:0] crd1 [3];
  logic [CoordBits-1:0] crdp [3];
  logic [PosBits-1:0]   pos [3];
  logic [2:0]           in_rng;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q[0] <= DimBits'(MaxDim);
      dim_q[1] <= DimBits'(MaxDim);
      dim_q[2] <= DimBits'(MaxDim);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DIM_X: dim_q[0] <= cfg_wdata_i;
        REG_DIM_Y: dim_q[1] <= cfg_wdata_i;
        REG_DIM_Z: dim_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pos[0] = item_i.pos_x;
  assign pos[1] = item_i.pos_y;
  assign pos[2] = item_i.pos_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // zero acts as one, above max acts as max
      if (dim_q[a] == '0) begin
        dm1[a] = '0;
      end else if (dim_q[a] > DimBits'(MaxDim)) begin
        dm1[a] = CoordBits'(MaxDim - 1);
      end else begin
        dm1[a] = CoordBits'(dim_q[a] - DimBits'(1));
      end
      in_rng[a] = pos[a] <= {dm1[a], {FracBits{1'b0}}};
      crd[a]    = pos[a][PosBits-1:FracBits];
      crd1[a]   = (crd[a] == dm1[a]) ? crd[a] : crd[a] + CoordBits'(1);
      crdp[a]   = crd[a] + CoordBits'(1);
    end
  end

  always_comb begin
    logic [CoordBits-1:0] cs, rs, ss;
    cmd_o.is_wr  = (func_e'(item_i.func) == FUNC_WRITE);
    cmd_o.in_vol = &in_rng;
    cmd_o.wbank  = {item_i.voxel_index[10], item_i.voxel_index[5], item_i.voxel_index[0]};
    cmd_o.waddr  = {item_i.voxel_index[14:11], item_i.voxel_index[9:6],
                    item_i.voxel_index[4:1]};
    cmd_o.wdata  = {item_i.write_z, item_i.write_y, item_i.write_x};
    cmd_o.raddr  = '0;
    for (int b = 0; b < NumBanks; b++) begin
      // each bank serves whichever corner coordinate has its parity
      cs = (crd[0][0] == b[0]) ? crd[0] : crdp[0];
      rs = (crd[1][0] == b[1]) ? crd[1] : crdp[1];
      ss = (crd[2][0] == b[2]) ? crd[2] : crdp[2];
      cmd_o.raddr[b*BankAw +: BankAw] = {ss[CoordBits-1:1], rs[CoordBits-1:1],
                                         cs[CoordBits-1:1]};
    end
    cmd_o.par0 = {crd[2][0], crd[1][0], crd[0][0]};
    cmd_o.par1 = {crd1[2][0], crd1[1][0], crd1[0][0]};
    cmd_o.tx   = item_i.pos_x[FracBits-1:0];
    cmd_o.ty   = item_i.pos_y[FracBits-1:0];
    cmd_o.tz   = item_i.pos_z[FracBits-1:0];
  end

endmodule

### rtl/vfts_queue.sv
module vfts_queue import vfts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cmd_t         push_data_i,
  input  logic         pop_i,
  output cmd_t         pop_data_o,
  output logic         full_o,
  output logic         empty_o,
  output logic [2:0]   cnt_o
);

  cmd_t       mem_q [QDepth];
  logic [1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 3'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign cnt_o      = cnt_q;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 2'd1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 2'd1 : rptr_q;
    cnt_d  = cnt_q + 3'(push_i) - 3'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/vfts_back.sv
module vfts_back import vfts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic en;
  voxel_t rd_data [NumBanks];

  // stage 1: memory access
  logic                s1_v_q, s1_smp_q, s1_in_q;
  logic [2:0]          s1_p0_q, s1_p1_q;
  logic [FracBits-1:0] s1_tx_q, s1_ty_q, s1_tz_q;
  // stage 2: x lerps
  logic                s2_v_q, s2_in_q;
  logic [FracBits-1:0] s2_ty_q, s2_tz_q;
  comp_t               e_q [3][4];
  // stage 3: y lerps
  logic                s3_v_q, s3_in_q;
  logic [FracBits-1:0] s3_tz_q;
  comp_t               f_q [3][2];
  // output
  logic                o_v_q;
  out_item_t           o_q;

  assign en        = !o_v_q || out_ready_i;
  assign cmd_pop_o = en && cmd_valid_i;

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    voxel_t bank_q [BankDepth];
    voxel_t rd_q;
    always_ff @(posedge clk_i) begin
      if (cmd_pop_o) begin
        if (cmd_i.is_wr) begin
          if (cmd_i.wbank == 3'(b)) begin
            bank_q[cmd_i.waddr] <= cmd_i.wdata;
          end
        end else begin
          rd_q <= bank_q[cmd_i.raddr[b*BankAw +: BankAw]];
        end
      end
    end
    assign rd_data[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en) begin
      s1_v_q <= cmd_valid_i && !cmd_i.is_wr;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      o_v_q  <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_smp_q <= !cmd_i.is_wr;
      s1_in_q  <= cmd_i.in_vol;
      s1_p0_q  <= cmd_i.par0;
      s1_p1_q  <= cmd_i.par1;
      s1_tx_q  <= cmd_i.tx;
      s1_ty_q  <= cmd_i.ty;
      s1_tz_q  <= cmd_i.tz;
    end
  end

  // corner j: bit0 x, bit1 y, bit2 z; a clamped corner reuses its lower bank
  always_ff @(posedge clk_i) begin
    logic [2:0] bsel [NumBanks];
    if (en) begin
      for (int j = 0; j < NumBanks; j++) begin
        bsel[j] = {j[2] ? s1_p1_q[2] : s1_p0_q[2],
                   j[1] ? s1_p1_q[1] : s1_p0_q[1],
                   j[0] ? s1_p1_q[0] : s1_p0_q[0]};
      end
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 4; m++) begin
          e_q[k][m] <= lerp(rd_data[bsel[2*m]][k*CompBits +: CompBits],
                            rd_data[bsel[2*m+1]][k*CompBits +: CompBits], s1_tx_q);
        end
      end
      s2_in_q <= s1_in_q && s1_smp_q;
      s2_ty_q <= s1_ty_q;
      s2_tz_q <= s1_tz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        f_q[k][0] <= lerp(e_q[k][0], e_q[k][1], s2_ty_q);
        f_q[k][1] <= lerp(e_q[k][2], e_q[k][3], s2_ty_q);
      end
      s3_in_q <= s2_in_q;
      s3_tz_q <= s2_tz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q.valid_res <= s3_in_q;
      o_q.out_x     <= s3_in_q ? lerp(f_q[0][0], f_q[0][1], s3_tz_q) : '0;
      o_q.out_y     <= s3_in_q ? lerp(f_q[1][0], f_q[1][1], s3_tz_q) : '0;
      o_q.out_z     <= s3_in_q ? lerp(f_q[2][0], f_q[2][1], s3_tz_q) : '0;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

endmodule

### rtl/vector_field_trilinear_sampler_core.sv
// an accepted sample passes the queue, memory read and x, y and z interpolation
// stages to its result; writes give no result
// throughput: one item per cycle while out_ready_i does not stall the output;
// the eight parity banks serve all corners at once; reset: dims return to 32,
// queue and pipeline empty; volume contents undefined until written
module vector_field_trilinear_sampler_core import vfts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [DimBits-1:0] cfg_wdata_i
);

  cmd_t       cmd_in, cmd_out;
  logic       q_full, q_empty, q_pop;
  logic [2:0] q_cnt;

  vfts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (in_data_i),
    .cmd_o       (cmd_in)
  );

  assign in_ready_o = !q_full;

  vfts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && in_ready_o),
    .push_data_i (cmd_in),
    .pop_i       (q_pop),
    .pop_data_o  (cmd_out),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .cnt_o       (q_cnt)
  );

  vfts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |->
      out_data_o.out_x == '0 && out_data_o.out_y == '0 && out_data_o.out_z == '0)
    else $error("outside sample with nonzero result");

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= 3'(QDepth))
    else $error("queue overflow");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_cnt == 3'(QDepth))
    else $error("input stalled without full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
